>>> design/s256h_pkg.sv
// Package: SHA-256 constants, types and round functions.
`timescale 1ns / 1ps
package s256h_pkg;

  localparam int NumRounds = 64;
  localparam int LenWidth  = 5;
  localparam logic [LenWidth-1:0] PadLimit = 5'd20;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] sched_t;
  typedef word_t [7:0] state_t;

  typedef struct packed {
    logic   valid;
    state_t st;
    sched_t w;
  } stage_t;

  localparam word_t RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam state_t StartH = '{
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t swap32(input word_t v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

>>> design/s256h_if.sv
// Interfaces: message word channel, digest channel, length write channel.
`timescale 1ns / 1ps
interface s256h_msg_if;
  logic        valid;
  logic        ready;
  logic [63:0] words_0_1;
  logic [63:0] words_2_3;
  logic [63:0] words_4_5;
  logic [63:0] words_6_7;
  logic [63:0] words_8_9;
  logic [63:0] words_10_11;
  logic [63:0] words_12_13;
  logic [31:0] word_14;
  modport source (output valid, words_0_1, words_2_3, words_4_5, words_6_7,
                  words_8_9, words_10_11, words_12_13, word_14, input ready);
  modport sink (input valid, words_0_1, words_2_3, words_4_5, words_6_7,
                words_8_9, words_10_11, words_12_13, word_14, output ready);
endinterface

interface s256h_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_h0;
  logic [31:0] digest_h1;
  logic [31:0] digest_h2;
  logic [31:0] digest_h3;
  logic [31:0] digest_h4;
  logic [31:0] digest_h5;
  logic [31:0] digest_h6;
  logic [31:0] digest_h7;
  modport source (output valid, digest_h0, digest_h1, digest_h2, digest_h3,
                  digest_h4, digest_h5, digest_h6, digest_h7, input ready);
  modport sink (input valid, digest_h0, digest_h1, digest_h2, digest_h3,
                digest_h4, digest_h5, digest_h6, digest_h7, output ready);
endinterface

interface s256h_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> design/s256h_round.sv
// One SHA-256 round stage with a rolling 16-word schedule window.
`timescale 1ns / 1ps
module s256h_round
  import s256h_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   advance,
  input  word_t  k,
  input  stage_t din,
  output stage_t dout
);

  word_t  t1, t2, s0, s1, wnew;
  state_t st;
  sched_t w;

  always_comb begin
    st = din.st;
    w  = din.w;
    t1 = st[7] + (rotr(st[4], 6) ^ rotr(st[4], 11) ^ rotr(st[4], 25))
       + ((st[4] & st[5]) ^ (~st[4] & st[6])) + k + w[0];
    t2 = (rotr(st[0], 2) ^ rotr(st[0], 13) ^ rotr(st[0], 22))
       + ((st[0] & st[1]) ^ (st[0] & st[2]) ^ (st[1] & st[2]));
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    wnew = w[0] + s0 + w[9] + s1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (advance) begin
      dout.valid <= din.valid;
    end
    if (advance) begin
      dout.st <= {st[6:4], st[3] + t1, st[2:0], t1 + t2};
      dout.w  <= {wnew, w[15:1]};
    end
  end

endmodule

>>> design/sha256_short_message_hash_core.sv
// Top level: pipelined single-block SHA-256 of short messages.
// An accepted word passes through the padding stage, the round stages and the output register to its digest.
// Throughput: one message per cycle while the digest is taken; 64 round stages, one per round,
// plus a padding stage and a final-add output register.
// The whole pipeline stalls together when the output word is not taken.
// Reset (rst, synchronous) clears all valid bits and message_length to 0.
`timescale 1ns / 1ps
module sha256_short_message_hash_core
  import s256h_pkg::*;
(
  input logic         clk,
  input logic         rst,
  s256h_cfg_if.sink   cfg,
  s256h_msg_if.sink   msg,
  s256h_dig_if.source dig
);

  logic [LenWidth-1:0] message_length;
  logic                advance;
  stage_t              pipe [NumRounds+1];
  sched_t              w_in;
  logic                out_valid;
  state_t              out_h;

  // Move everything when the output register is free or being drained.
  assign advance   = !out_valid || dig.ready;
  assign msg.ready = advance;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      message_length <= '0;
    end else if (cfg.valid) begin
      message_length <= cfg.data;
    end
  end

  // Build the padded, byte-swapped block.
  always_comb begin
    sched_t raw;
    raw = '0;
    raw[0]  = msg.words_0_1[31:0];   raw[1]  = msg.words_0_1[63:32];
    raw[2]  = msg.words_2_3[31:0];   raw[3]  = msg.words_2_3[63:32];
    raw[4]  = msg.words_4_5[31:0];   raw[5]  = msg.words_4_5[63:32];
    raw[6]  = msg.words_6_7[31:0];   raw[7]  = msg.words_6_7[63:32];
    raw[8]  = msg.words_8_9[31:0];   raw[9]  = msg.words_8_9[63:32];
    raw[10] = msg.words_10_11[31:0]; raw[11] = msg.words_10_11[63:32];
    raw[12] = msg.words_12_13[31:0]; raw[13] = msg.words_12_13[63:32];
    raw[14] = msg.word_14;
    // Pad byte only for message lengths below PadLimit.
    if (message_length < PadLimit) begin
      raw[{1'b0, message_length[4:2]}] = raw[{1'b0, message_length[4:2]}]
                               | (word_t'(8'h80) << {message_length[1:0], 3'b000});
    end
    for (int i = 0; i < 15; i++) begin
      w_in[i] = swap32(raw[i]);
    end
    w_in[15] = {24'd0, message_length, 3'b000};
  end

  // Stage zero: registered padded block and initial state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[0].valid <= 1'b0;
    end else if (advance) begin
      pipe[0].valid <= msg.valid;
    end
    if (advance) begin
      pipe[0].st <= StartH;
      pipe[0].w  <= w_in;
    end
  end

  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    s256h_round u_round (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .k       (RoundK[r]),
      .din     (pipe[r]),
      .dout    (pipe[r+1])
    );
  end

  // Final add into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= pipe[NumRounds].valid;
    end
    if (advance) begin
      for (int i = 0; i < 8; i++) begin
        out_h[i] <= pipe[NumRounds].st[i] + StartH[i];
      end
    end
  end

  assign dig.valid     = out_valid;
  assign dig.digest_h0 = out_h[0];
  assign dig.digest_h1 = out_h[1];
  assign dig.digest_h2 = out_h[2];
  assign dig.digest_h3 = out_h[3];
  assign dig.digest_h4 = out_h[4];
  assign dig.digest_h5 = out_h[5];
  assign dig.digest_h6 = out_h[6];
  assign dig.digest_h7 = out_h[7];

  // A stalled digest must hold.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !dig.ready |=> out_valid && $stable(out_h))
    else $error("digest changed while stalled");
  // Stall freezes the last round's valid bit.
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(pipe[NumRounds].valid))
    else $error("pipeline moved during stall");
  // Accepted word shows up at stage zero.
  a_enter: assert property (@(posedge clk) disable iff (rst)
    msg.valid && msg.ready |=> pipe[0].valid)
    else $error("accepted word lost");

endmodule
